>>> hdl/ab_boot_slot_manager_unit_assert.svh
// Assertion macros for the A/B boot slot manager.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef AB_BOOT_SLOT_MANAGER_UNIT_ASSERT_SVH
`define AB_BOOT_SLOT_MANAGER_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define ABSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ABSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/absm_pkg.sv
// Shared types and codes for the A/B boot slot manager.
// No dependencies; used by absm_core and ab_boot_slot_manager_unit.
package absm_pkg;

  typedef enum logic [1:0] {
    OP_SELECT      = 2'd0,
    OP_SET_PRIMARY = 2'd1,
    OP_SET_GOOD    = 2'd2,
    OP_LOAD        = 2'd3
  } op_e;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_CONFIRMED = 2'd1;
  localparam logic [1:0] ST_TRIAL     = 2'd2;
  localparam logic [1:0] ST_ACCEPTED  = 2'd3;

  localparam logic [1:0] CFG_PRIMARY_PRIORITY  = 2'd0;
  localparam logic [1:0] CFG_FALLBACK_PRIORITY = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_TRIES     = 2'd2;

  localparam logic [7:0] PRIMARY_PRIORITY_RST  = 8'd15;
  localparam logic [7:0] FALLBACK_PRIORITY_RST = 8'd14;
  localparam logic [7:0] DEFAULT_TRIES_RST     = 8'd3;

  typedef struct packed {
    logic [7:0] primary_priority;
    logic [7:0] fallback_priority;
    logic [7:0] default_tries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  target_slot;
    logic        mark_good;
    logic [31:0] load_generation;
    logic [7:0]  load_active;
    logic [7:0]  load_prio_a;
    logic [7:0]  load_prio_b;
    logic [7:0]  load_tries_a;
    logic [7:0]  load_tries_b;
    logic [7:0]  load_good_a;
    logic [7:0]  load_good_b;
  } item_t;

  // Slot 0 is A, slot 1 is B.
  typedef struct packed {
    logic [31:0]     generation;
    logic            active;
    logic [1:0][7:0] prio;
    logic [1:0][7:0] tries;
    logic [1:0]      good;
  } slot_state_t;

endpackage

>>> hdl/absm_core.sv
// Next-state and status logic for one boot-control operation.
// Purely combinational; depends on absm_pkg.
module absm_core (
  input  absm_pkg::item_t       item,
  input  absm_pkg::cfg_t        cfg,
  input  absm_pkg::slot_state_t cur,
  output absm_pkg::slot_state_t nxt,
  output logic [1:0]            status,
  output logic                  selected
);
  import absm_pkg::*;

  logic [1:0]  bootable;
  logic        any_boot;
  logic        win;
  logic        tgt_ok;
  logic        tgt;
  logic        other;
  logic        load_ok;
  logic [31:0] gen_inc;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      bootable[i] = (cur.prio[i] != 8'd0) && (cur.good[i] || (cur.tries[i] != 8'd0));
    end
    any_boot = |bootable;
    // With both slots bootable the higher priority wins and a tie goes to the active slot.
    if (bootable[0] && bootable[1]) begin
      if (cur.prio[0] > cur.prio[1]) begin
        win = 1'b0;
      end else if (cur.prio[1] > cur.prio[0]) begin
        win = 1'b1;
      end else begin
        win = cur.active;
      end
    end else begin
      win = bootable[1];
    end
    tgt_ok  = (item.target_slot[7:1] == 7'd0);
    tgt     = item.target_slot[0];
    other   = ~tgt;
    load_ok = (item.load_active[7:1] == 7'd0) && (item.load_good_a[7:1] == 7'd0) &&
              (item.load_good_b[7:1] == 7'd0);
    gen_inc = cur.generation + 32'd1;
  end

  always_comb begin
    nxt      = cur;
    status   = ST_NONE;
    selected = 1'b0;
    case (op_e'(item.operation))
      OP_SELECT: begin
        if (any_boot) begin
          selected = win;
          if (cur.good[win]) begin
            status = ST_CONFIRMED;
            if (win != cur.active) begin
              nxt.active     = win;
              nxt.generation = gen_inc;
            end
          end else begin
            status          = ST_TRIAL;
            nxt.active      = win;
            nxt.tries[win]  = cur.tries[win] - 8'd1;
            nxt.generation  = gen_inc;
          end
        end
      end
      OP_SET_PRIMARY: begin
        if (tgt_ok) begin
          status         = ST_ACCEPTED;
          nxt.active     = tgt;
          nxt.prio[tgt]  = cfg.primary_priority;
          nxt.tries[tgt] = cfg.default_tries;
          if (bootable[other]) begin
            nxt.prio[other] = cfg.fallback_priority;
          end
          nxt.generation = gen_inc;
        end
      end
      OP_SET_GOOD: begin
        if (tgt_ok) begin
          status = ST_ACCEPTED;
          if (item.mark_good) begin
            nxt.good[tgt]  = 1'b1;
            nxt.tries[tgt] = cfg.default_tries;
            if (cur.prio[tgt] == 8'd0) begin
              nxt.prio[tgt] = (tgt == cur.active) ? cfg.primary_priority
                                                  : cfg.fallback_priority;
            end
          end else begin
            nxt.good[tgt]  = 1'b0;
            nxt.tries[tgt] = 8'd0;
            nxt.prio[tgt]  = 8'd0;
          end
          nxt.generation = gen_inc;
        end
      end
      OP_LOAD: begin
        if (load_ok) begin
          status         = ST_ACCEPTED;
          nxt.generation = item.load_generation;
          nxt.active     = item.load_active[0];
          nxt.prio[0]    = item.load_prio_a;
          nxt.prio[1]    = item.load_prio_b;
          nxt.tries[0]   = item.load_tries_a;
          nxt.tries[1]   = item.load_tries_b;
          nxt.good[0]    = item.load_good_a[0];
          nxt.good[1]    = item.load_good_b[0];
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> hdl/ab_boot_slot_manager_unit.sv
// Top level of the A/B boot slot manager: input stage, state, config and result register.
// Depends on absm_pkg, absm_core and ab_boot_slot_manager_unit_assert.svh.
//
//   Channel   Signals                                  Direction
//   in_       in_valid/in_ready + operation, load data  into block
//   out_      out_valid/out_ready + status and state    out of block
//   cfg_      cfg_we, cfg_index, cfg_wdata              into block
//
// An item passes from its transfer into the input register, then through the operation
// logic into the result register, where the slot state is updated on the same edge. One
// item per cycle is sustained while out_ready stays high. A stalled result holds the
// input stage; in_ready still rises when the stage drains. Reset is synchronous and
// restores the register defaults and an all-zero slot state.
module ab_boot_slot_manager_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_target_slot,
  input  logic        in_mark_good,
  input  logic [31:0] in_load_generation,
  input  logic [7:0]  in_load_active,
  input  logic [7:0]  in_load_prio_a,
  input  logic [7:0]  in_load_prio_b,
  input  logic [7:0]  in_load_tries_a,
  input  logic [7:0]  in_load_tries_b,
  input  logic [7:0]  in_load_good_a,
  input  logic [7:0]  in_load_good_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_boot_slot,
  output logic [31:0] out_generation,
  output logic        out_active,
  output logic [7:0]  out_prio_a,
  output logic [7:0]  out_prio_b,
  output logic [7:0]  out_tries_a,
  output logic [7:0]  out_tries_b,
  output logic        out_good_a,
  output logic        out_good_b,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import absm_pkg::*;

  `include "ab_boot_slot_manager_unit_assert.svh"

  cfg_t        cfg_r;
  logic        s1_valid_r;
  item_t       s1_item_r;
  slot_state_t state_r;
  slot_state_t state_nxt;
  logic [1:0]  status_nxt;
  logic        selected_nxt;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_selected_r;
  slot_state_t out_state_r;
  logic        s1_advance;
  logic        in_xfer;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_xfer    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.primary_priority  <= PRIMARY_PRIORITY_RST;
      cfg_r.fallback_priority <= FALLBACK_PRIORITY_RST;
      cfg_r.default_tries     <= DEFAULT_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIMARY_PRIORITY:  cfg_r.primary_priority  <= cfg_wdata;
        CFG_FALLBACK_PRIORITY: cfg_r.fallback_priority <= cfg_wdata;
        CFG_DEFAULT_TRIES:     cfg_r.default_tries     <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.operation       <= in_operation;
      s1_item_r.target_slot     <= in_target_slot;
      s1_item_r.mark_good       <= in_mark_good;
      s1_item_r.load_generation <= in_load_generation;
      s1_item_r.load_active     <= in_load_active;
      s1_item_r.load_prio_a     <= in_load_prio_a;
      s1_item_r.load_prio_b     <= in_load_prio_b;
      s1_item_r.load_tries_a    <= in_load_tries_a;
      s1_item_r.load_tries_b    <= in_load_tries_b;
      s1_item_r.load_good_a     <= in_load_good_a;
      s1_item_r.load_good_b     <= in_load_good_b;
    end
  end

  absm_core u_core (
    .item     (s1_item_r),
    .cfg      (cfg_r),
    .cur      (state_r),
    .nxt      (state_nxt),
    .status   (status_nxt),
    .selected (selected_nxt)
  );

  // The state only moves when its result is written, so a held result always
  // matches the current state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_status_r   <= status_nxt;
      out_selected_r <= selected_nxt;
      out_state_r    <= state_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_boot_slot  = out_selected_r;
  assign out_generation = out_state_r.generation;
  assign out_active     = out_state_r.active;
  assign out_prio_a     = out_state_r.prio[0];
  assign out_prio_b     = out_state_r.prio[1];
  assign out_tries_a    = out_state_r.tries[0];
  assign out_tries_b    = out_state_r.tries[1];
  assign out_good_a     = out_state_r.good[0];
  assign out_good_b     = out_state_r.good[1];

  `ABSM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")
  `ABSM_ASSERT(a_held_matches_state, out_valid_r |-> out_state_r == state_r, "held result differs from slot state")
  `ABSM_ASSERT(a_none_keeps_gen, s1_advance && status_nxt == ST_NONE |=> state_r.generation == $past(state_r.generation), "rejected operation changed generation")
  `ABSM_ASSERT(a_sel_only_on_boot, out_valid_r && out_selected_r |-> out_status_r == ST_CONFIRMED || out_status_r == ST_TRIAL, "slot reported without a boot")
  `ABSM_ASSERT(a_stage_kept, s1_valid_r && !s1_advance |=> s1_valid_r, "stalled item dropped")

endmodule
